>>> rtl/dfdt_pkg.sv
// Shared constants and types for the Doppler fractional delay tap block.
package dfdt_pkg;

	// Field widths fixed by the item format
	localparam int CUR_W      = 32;
	localparam int TAP_IN_W   = 6;
	localparam int DLY_W      = 30;
	localparam int DLEN_REG_W = 15;
	localparam int BLEN_REG_W = 7;

	// Fixed point
	localparam int FRAC_BITS  = 16;
	localparam int ONE_Q      = 1 << FRAC_BITS;
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

	// Iterative divider: dividend width, quotient bits per cycle
	localparam int DIV_W         = 32;
	localparam int DIV_STEP_BITS = 2;
	localparam int DIV_CYCLES    = DIV_W / DIV_STEP_BITS;
	localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

	// Register reset values
	localparam logic [DLEN_REG_W-1:0] DLEN_RESET = 15'd16384;
	localparam logic [BLEN_REG_W-1:0] BLEN_RESET = 7'd64;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic {
		REG_DELAY_LEN = 1'b0,
		REG_BLOCK_LEN = 1'b1
	} reg_sel_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

endpackage

>>> rtl/dfdt_div.sv
// Shared multi-cycle unsigned divider: quotient and remainder, two bits per cycle.
module dfdt_div #(
	parameter int DVS_W = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [dfdt_pkg::DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0]        divisor,
	output logic                    done,
	output logic [dfdt_pkg::DIV_W-1:0] quot,
	output logic [DVS_W-1:0]        rem
);
	import dfdt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     num_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DIV_W-1:0]     num_nxt;
	logic [DVS_W-1:0]     rem_nxt;

	// restoring steps; quotient bits shift into num from the bottom
	always_comb begin
		logic [DVS_W:0] rs;
		num_nxt = num_q;
		rem_nxt = rem_q;
		for (int i = 0; i < DIV_STEP_BITS; i++) begin
			rs      = {rem_nxt, num_nxt[DIV_W-1]};
			num_nxt = {num_nxt[DIV_W-2:0], 1'b0};
			if (rs >= {1'b0, dvs_q}) begin
				rs         = rs - {1'b0, dvs_q};
				num_nxt[0] = 1'b1;
			end
			rem_nxt = rs[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

>>> rtl/doppler_fractional_delay_tap_core.sv
// Top level of the Doppler fractional delay tap: delay memory, tap table and read sequencer.
//
// A circular delay line of DELAY_DEPTH samples with up to NUM_TAPS moving read taps.
// A write item (tuser = 0) stores sample_in at current_sample mod delay_len and gives no
// output; its address is the remainder from the shared divider. A read item
// (tuser = 1) clamps its Q14.16 delay to delay_len-1 samples, stores it for the tap and
// emits block_len linearly interpolated samples, tlast on the final one. The read
// position starts at current_sample mod delay_len minus the delay and steps by
// 1 + (delay - previous delay) / block_len, wrapping modulo delay_len; an unused tap
// steps by exactly one sample. A read makes three passes of the shared divider (base
// index, step, step mod wrap span) with a setup state before the last, then gives one
// sample per cycle from the dual-read delay memory while the output is not stalled; the
// next item is taken only once the interpolation pipe has drained. After reset the
// delay memory is swept to zero with s_tready low; register writes are taken during the
// sweep. Registers: delay_len at 0x0, block_len at 0x4; out-of-range values are clamped
// to [2, DELAY_DEPTH] and [1, MAX_BLOCK]. Change them only while idle.
module doppler_fractional_delay_tap_core #(
	parameter int DELAY_DEPTH = 16384,
	parameter int MAX_BLOCK   = 64,
	parameter int NUM_TAPS    = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,

	// input items
	input  logic s_tvalid,
	output logic s_tready,
	// current_sample, sample_in, tap_index, delay_location, zero pad
	input  logic [((dfdt_pkg::CUR_W + SAMPLE_BITS + dfdt_pkg::TAP_IN_W
		+ dfdt_pkg::DLY_W + 7) / 8) * 8 - 1:0] s_tdata,
	// cmd
	input  logic s_tuser,

	// result items
	output logic m_tvalid,
	input  logic m_tready,
	// sample_out, zero pad
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	output logic m_tlast,

	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [dfdt_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [dfdt_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [dfdt_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import dfdt_pkg::*;

	localparam int AW        = $clog2(DELAY_DEPTH);
	localparam int LEN_W     = AW + 1;
	localparam int SPAN_W    = LEN_W + FRAC_BITS;
	localparam int BLK_W     = $clog2(MAX_BLOCK + 1);
	localparam int TAP_W     = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
	localparam int TAP_CODES = 1 << TAP_IN_W;
	localparam int OUT_W     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int SMP_LO    = CUR_W;
	localparam int TAP_LO    = CUR_W + SAMPLE_BITS;
	localparam int DLY_LO    = TAP_LO + TAP_IN_W;
	localparam int CMP_W     = ((SPAN_W > DLY_W) ? SPAN_W : DLY_W) + 1;
	localparam int PROD_W    = SAMPLE_BITS + FRAC_BITS + 2;

	// tap_index mod NUM_TAPS, worked out at elaboration
	function automatic logic [TAP_CODES*TAP_W-1:0] build_tap_lut();
		logic [TAP_CODES*TAP_W-1:0] lut;
		lut = '0;
		for (int i = 0; i < TAP_CODES; i++)
			lut[i*TAP_W +: TAP_W] = TAP_W'(i % NUM_TAPS);
		return lut;
	endfunction

	localparam logic [TAP_CODES*TAP_W-1:0] TAP_LUT = build_tap_lut();

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BASE,
		ST_DELTA,
		ST_SCALC,
		ST_STEP,
		ST_RUN
	} state_t;

	// ---------------------------------------------------------------- registers
	logic [DLEN_REG_W-1:0] delay_len_q;
	logic [BLEN_REG_W-1:0] block_len_q;
	logic                  cfg_we;
	reg_sel_t              reg_sel;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_sel = reg_sel_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_len_q <= DLEN_RESET;
			block_len_q <= BLEN_RESET;
		end else if (cfg_we) begin
			case (reg_sel)
				REG_DELAY_LEN: delay_len_q <= pwdata[DLEN_REG_W-1:0];
				REG_BLOCK_LEN: block_len_q <= pwdata[BLEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_DELAY_LEN: prdata = APB_DATA_W'(delay_len_q);
			REG_BLOCK_LEN: prdata = APB_DATA_W'(block_len_q);
			default:       prdata = '0;
		endcase
	end

	// clamped lengths
	logic [LEN_W-1:0]  len_eff;
	logic [BLK_W-1:0]  blk_eff;
	logic [SPAN_W-1:0] span;
	logic [SPAN_W-1:0] max_dly;

	always_comb begin
		if (32'(delay_len_q) < 32'd2)
			len_eff = LEN_W'(2);
		else if (32'(delay_len_q) > 32'(DELAY_DEPTH))
			len_eff = LEN_W'(DELAY_DEPTH);
		else
			len_eff = LEN_W'(delay_len_q);
		if (block_len_q == '0)
			blk_eff = BLK_W'(1);
		else if (32'(block_len_q) > 32'(MAX_BLOCK))
			blk_eff = BLK_W'(MAX_BLOCK);
		else
			blk_eff = BLK_W'(block_len_q);
	end

	assign span    = {len_eff, {FRAC_BITS{1'b0}}};
	assign max_dly = {len_eff - LEN_W'(1), {FRAC_BITS{1'b0}}};

	// ---------------------------------------------------------------- input side
	state_t                  state_q;
	logic                    v_s0, v_s1, v_s2;
	logic                    in_acc;
	cmd_t                    cmd_in;
	logic [TAP_IN_W-1:0]     tap_raw;
	logic [TAP_W-1:0]        tap_in;
	logic [DLY_W-1:0]        dly_raw;
	logic [DLY_W-1:0]        dly_clamped;

	assign s_tready = (state_q == ST_IDLE) && !(v_s0 || v_s1 || v_s2);
	assign in_acc   = s_tvalid && s_tready;
	assign cmd_in   = cmd_t'(s_tuser);
	assign tap_raw  = s_tdata[TAP_LO +: TAP_IN_W];
	assign tap_in   = TAP_LUT[tap_raw*TAP_W +: TAP_W];
	assign dly_raw  = s_tdata[DLY_LO +: DLY_W];
	// clamped delay is below 2^30 either way
	assign dly_clamped = (CMP_W'(dly_raw) > CMP_W'(max_dly)) ? DLY_W'(max_dly) : dly_raw;

	// ---------------------------------------------------------------- item registers
	cmd_t                    cmd_q;
	logic [SAMPLE_BITS-1:0]  smp_q;
	logic [TAP_W-1:0]        tap_q;
	logic [DLY_W-1:0]        dly_q;
	logic [DLY_W-1:0]        prev_rd_q;
	logic [LEN_W-1:0]        base_q;
	logic [DLY_W:0]          delta_q;     // two's complement
	logic [DIV_W-1:0]        step_q;      // two's complement, Q.16
	logic [SPAN_W-1:0]       stepm_q;     // step mod span
	logic [SPAN_W-1:0]       pos_q;
	logic [BLK_W-1:0]        k_q;
	logic [AW-1:0]           clr_addr_q;
	logic [NUM_TAPS-1:0]     known_q;

	// ---------------------------------------------------------------- divider
	logic              div_start;
	logic [DIV_W-1:0]  div_dvd;
	logic [SPAN_W-1:0] div_dvs;
	logic              div_done;
	logic [DIV_W-1:0]  div_quot;
	logic [SPAN_W-1:0] div_rem;
	logic [DLY_W:0]    delta_mag;
	logic [DIV_W-1:0]  step_mag;

	assign delta_mag = delta_q[DLY_W] ? (~delta_q + 1'b1) : delta_q;
	assign step_mag  = step_q[DIV_W-1] ? (~step_q + 1'b1) : step_q;

	// one unit, three jobs: base index, step quotient, step mod span
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		case (state_q)
			ST_IDLE: begin
				div_start = in_acc;
				div_dvd   = s_tdata[CUR_W-1:0];
				div_dvs   = SPAN_W'(len_eff);
			end
			ST_BASE: begin
				div_start = div_done && (cmd_q == CMD_READ);
				div_dvd   = DIV_W'(delta_mag);
				div_dvs   = SPAN_W'(blk_eff);
			end
			ST_SCALC: begin
				div_start = 1'b1;
				div_dvd   = step_mag;
				div_dvs   = span;
			end
			default: ;
		endcase
	end

	dfdt_div #(
		.DVS_W (SPAN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// ---------------------------------------------------------------- position math
	logic [DIV_W-1:0]  quot_sgn;
	logic [DIV_W-1:0]  step_nxt;
	logic [SPAN_W:0]   pos_diff;
	logic [SPAN_W-1:0] pos0;
	logic [SPAN_W-1:0] stepm_nxt;
	logic [SPAN_W:0]   pos_add;
	logic [SPAN_W-1:0] pos_nxt;
	logic [LEN_W-1:0]  ip;
	logic [LEN_W-1:0]  ipn_raw;
	logic [LEN_W-1:0]  ipn;
	logic              blk_last;
	logic              adv;

	// division truncates toward zero: divide magnitude, then restore sign
	assign quot_sgn = delta_q[DLY_W] ? (~div_quot + 1'b1) : div_quot;
	assign step_nxt = quot_sgn + DIV_W'(ONE_Q);

	// start position; delay is below span so one add-back wraps it
	assign pos_diff = {1'b0, base_q, {FRAC_BITS{1'b0}}} - {1'b0, SPAN_W'(dly_q)};
	assign pos0     = pos_diff[SPAN_W] ? SPAN_W'(pos_diff + {1'b0, span})
		: pos_diff[SPAN_W-1:0];

	// negative step: map remainder of the magnitude into [0, span)
	assign stepm_nxt = (step_q[DIV_W-1] && (div_rem != '0)) ? (span - div_rem) : div_rem;

	assign pos_add = {1'b0, pos_q} + {1'b0, stepm_q};
	assign pos_nxt = (pos_add >= {1'b0, span}) ? SPAN_W'(pos_add - {1'b0, span})
		: pos_add[SPAN_W-1:0];

	assign ip       = pos_q[SPAN_W-1:FRAC_BITS];
	assign ipn_raw  = ip + 1'b1;
	assign ipn      = (ipn_raw == len_eff) ? '0 : ipn_raw;
	assign blk_last = (k_q == blk_eff - 1'b1);

	logic m_tvalid_q;
	assign adv = !m_tvalid_q || m_tready;

	// ---------------------------------------------------------------- sequencer
	logic prev_we;
	assign prev_we = (state_q == ST_BASE) && div_done && (cmd_q == CMD_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			k_q        <= '0;
			known_q    <= '0;
		end else begin
			if (prev_we)
				known_q[tap_q] <= 1'b1;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DELAY_DEPTH - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_BASE;
				end
				ST_BASE: begin
					if (div_done)
						state_q <= (cmd_q == CMD_WRITE) ? ST_IDLE : ST_DELTA;
				end
				ST_DELTA: begin
					if (div_done)
						state_q <= ST_SCALC;
				end
				ST_SCALC: state_q <= ST_STEP;
				ST_STEP: begin
					if (div_done) begin
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv) begin
						k_q <= k_q + 1'b1;
						if (blk_last)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd_in;
			smp_q <= s_tdata[SMP_LO +: SAMPLE_BITS];
			tap_q <= tap_in;
			dly_q <= dly_clamped;
		end
		case (state_q)
			ST_BASE: begin
				// prev_rd_q is valid from the first cycle here
				delta_q <= known_q[tap_q] ? ({1'b0, dly_q} - {1'b0, prev_rd_q}) : '0;
				if (div_done)
					base_q <= LEN_W'(div_rem);
			end
			ST_DELTA: begin
				if (div_done) begin
					step_q <= step_nxt;
					pos_q  <= pos0;
				end
			end
			ST_STEP: begin
				if (div_done)
					stepm_q <= stepm_nxt;
			end
			ST_RUN: begin
				if (adv)
					pos_q <= pos_nxt;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- tap delay table
	logic [DLY_W-1:0] prev_mem [NUM_TAPS];

	always_ff @(posedge clk) begin
		if (prev_we)
			prev_mem[tap_q] <= dly_q;
		if (in_acc)
			prev_rd_q <= prev_mem[tap_in];
	end

	// ---------------------------------------------------------------- delay memory
	logic [SAMPLE_BITS-1:0] delay_mem [DELAY_DEPTH];
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic [AW-1:0]          addr_a_s0, addr_b_s0;
	logic [SAMPLE_BITS-1:0] rd_a_s1, rd_b_s1;

	assign mem_we    = (state_q == ST_CLEAR)
		|| ((state_q == ST_BASE) && div_done && (cmd_q == CMD_WRITE));
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_addr_q : AW'(div_rem);
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : smp_q;

	// two read ports (sample and its neighbor), held while the output stalls
	always_ff @(posedge clk) begin
		if (mem_we)
			delay_mem[mem_waddr] <= mem_wdata;
		if (adv) begin
			rd_a_s1 <= delay_mem[addr_a_s0];
			rd_b_s1 <= delay_mem[addr_b_s0];
		end
	end

	// ---------------------------------------------------------------- interpolation pipe
	logic [FRAC_BITS-1:0]          frac_s0, frac_s1;
	logic                          last_s0, last_s1, last_s2;
	logic signed [SAMPLE_BITS:0]   dif_s1;
	logic signed [PROD_W-1:0]      prod_c, prod_s2, rnd;
	logic [SAMPLE_BITS-1:0]        a_s2;
	logic [SAMPLE_BITS+1:0]        ysum;
	logic [SAMPLE_BITS-1:0]        out_q;
	logic                          last_q;

	assign dif_s1 = $signed({rd_b_s1[SAMPLE_BITS-1], rd_b_s1})
		- $signed({rd_a_s1[SAMPLE_BITS-1], rd_a_s1});
	assign prod_c = PROD_W'(dif_s1) * PROD_W'($signed({1'b0, frac_s1}));
	// round half up, floor shift
	assign rnd    = prod_s2 + $signed(PROD_W'(ROUND_HALF));
	assign ysum   = {{2{a_s2[SAMPLE_BITS-1]}}, a_s2} + (SAMPLE_BITS+2)'(rnd >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0       <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			v_s0       <= (state_q == ST_RUN);
			v_s1       <= v_s0;
			v_s2       <= v_s1;
			m_tvalid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addr_a_s0 <= AW'(ip);
			addr_b_s0 <= AW'(ipn);
			frac_s0   <= pos_q[FRAC_BITS-1:0];
			last_s0   <= blk_last;
			frac_s1   <= frac_s0;
			last_s1   <= last_s0;
			prod_s2   <= prod_c;
			a_s2      <= rd_a_s1;
			last_s2   <= last_s1;
			out_q     <= ysum[SAMPLE_BITS-1:0];
			last_q    <= last_s2;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(out_q);
	assign m_tlast  = last_q;

`ifndef SYNTH
	// a memory write must never race a sample read still in flight
	a_no_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !(v_s0 || v_s1 || v_s2))
		else $error("delay memory written while reads in flight");

	// every divider result is consumed by a waiting state
	a_div_done_used: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_BASE || state_q == ST_DELTA || state_q == ST_STEP))
		else $error("divider result dropped");

	// read position stays inside the wrap span
	a_pos_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (pos_q < span))
		else $error("read position out of span");

	// the final sample of a block is issued as the sequencer returns to idle
	a_last_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s0 && last_s0) |-> (state_q == ST_IDLE))
		else $error("block end out of step with sequencer");
`endif

endmodule
